### rtl/wgm_pkg.sv
// wgm_pkg: types and constants shared by the glob matcher modules
// no dependencies; imported by wgm_cell, wgm_chain and wildcard_glob_matcher

package wgm_pkg;

    localparam int MAX_PATTERN = 64;

    localparam logic [7:0] STAR_SYM = 8'h2A;
    localparam logic [7:0] ANY_SYM  = 8'h3F;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_BEGIN  = 2'd2,
        OP_TEXT   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_APPEND,
        CELL_BEGIN,
        CELL_TEXT,
        CELL_RIPPLE
    } cell_op_t;

    typedef struct packed {
        cell_op_t   op;
        logic [7:0] symbol;
    } cell_cmd_t;

    typedef struct packed {
        logic pending;
        logic matched;
        logic full;
    } chain_stat_t;

    typedef enum logic {
        ST_IDLE,
        ST_RIPPLE
    } state_t;

endpackage

### rtl/wgm_cell.sv
// wgm_cell: one pattern position; holds a pattern byte, its in-use bit and its match bit
// depends on wgm_pkg

module wgm_cell
    import wgm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  logic      left_match,
    input  logic      left_active,
    output logic      match,
    output logic      active,
    output logic      pending
);

    logic [7:0] sym_reg;
    logic [7:0] sym_next;
    logic       active_reg;
    logic       active_next;
    logic       match_reg;
    logic       match_next;
    logic       is_star;
    logic       hit;

    assign is_star = (sym_reg == STAR_SYM);
    assign hit     = (sym_reg == ANY_SYM) || (sym_reg == cmd.symbol);

    // a star cell still has to take in the bit on its left
    assign pending = active_reg && is_star && left_match && !match_reg;

    always_comb
    begin
        sym_next    = sym_reg;
        active_next = active_reg;
        match_next  = match_reg;
        unique case (cmd.op)
            CELL_CLEAR:
            begin
                active_next = 1'b0;
                match_next  = 1'b0;
            end
            CELL_APPEND:
            begin
                // first free cell takes the byte
                if (left_active && !active_reg)
                begin
                    sym_next    = cmd.symbol;
                    active_next = 1'b1;
                end
                match_next = 1'b0;
            end
            CELL_BEGIN:
            begin
                match_next = 1'b0;
            end
            CELL_TEXT:
            begin
                if (!active_reg)
                    match_next = 1'b0;
                else if (is_star)
                    match_next = match_reg;
                else if (hit)
                    match_next = left_match;
                else
                    match_next = 1'b0;
            end
            CELL_RIPPLE:
            begin
                if (active_reg && is_star && left_match)
                    match_next = 1'b1;
            end
            default:
            begin
                match_next = match_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            match_reg  <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            match_reg  <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg <= sym_next;
    end

    assign match  = match_reg;
    assign active = active_reg;

endmodule

### rtl/wgm_chain.sv
// wgm_chain: row of MAX_PATTERN cells, each fed by its left neighbor
// depends on wgm_pkg and wgm_cell

module wgm_chain
    import wgm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cell_cmd_t   cmd,
    input  logic        bit0,
    output chain_stat_t stat
);

    logic [MAX_PATTERN:0]   mt;
    logic [MAX_PATTERN:0]   act;
    logic [MAX_PATTERN-1:0] pend;
    logic [MAX_PATTERN:0]   last_hit;

    // position zero is the empty pattern prefix, always in use
    assign mt[0]  = bit0;
    assign act[0] = 1'b1;

    for (genvar j = 1; j <= MAX_PATTERN; j++)
    begin : g_cell
        wgm_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left_match  (mt[j-1]),
            .left_active (act[j-1]),
            .match       (mt[j]),
            .active      (act[j]),
            .pending     (pend[j-1])
        );
    end

    // the last cell in use carries the whole-pattern result
    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
            last_hit[j] = mt[j] && act[j] && !act[j+1];
        last_hit[MAX_PATTERN] = mt[MAX_PATTERN] && act[MAX_PATTERN];
    end

    assign stat.pending = |pend;
    assign stat.matched = |last_hit;
    assign stat.full    = act[MAX_PATTERN];

endmodule

### rtl/wildcard_glob_matcher.sv
// flow: an item is taken, then star runs fill in one cell per cycle; for a begin or text item
// the result is loaded into the output register once no star cell is pending and the output
// slot is free, so a stalled output holds it back; a new item is taken only after the row has
// settled and any result of the last item has been handed over
// reset: empty pattern, overflow clear, bit zero set; the block takes items right after reset
// wildcard_glob_matcher: top level, handshake and control around the cell row
// depends on wgm_pkg and wgm_chain

module wildcard_glob_matcher
    import wgm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // symbol
    input  logic [1:0] s_tuser,   // opcode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // matched, pattern_overflow, zero fill
);

    state_t      state_reg;
    state_t      state_next;
    logic        want_out_reg;
    logic        want_out_next;
    logic        bit0_reg;
    logic        bit0_next;
    logic        ovf_reg;
    logic        ovf_next;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [1:0]  res_reg;
    logic [1:0]  res_next;
    logic        accept;
    op_t         op;
    cell_cmd_t   cmd;
    chain_stat_t stat;

    assign op       = op_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next    = state_reg;
        want_out_next = want_out_reg;
        bit0_next     = bit0_reg;
        ovf_next      = ovf_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        res_next      = res_reg;
        cmd.op        = CELL_HOLD;
        cmd.symbol    = s_tdata;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RIPPLE;
                    unique case (op)
                        OP_CLEAR:
                        begin
                            cmd.op        = CELL_CLEAR;
                            bit0_next     = 1'b1;
                            ovf_next      = 1'b0;
                            want_out_next = 1'b0;
                        end
                        OP_APPEND:
                        begin
                            cmd.op        = CELL_APPEND;
                            bit0_next     = 1'b1;
                            want_out_next = 1'b0;
                            if (stat.full)
                                ovf_next = 1'b1;
                        end
                        OP_BEGIN:
                        begin
                            cmd.op        = CELL_BEGIN;
                            bit0_next     = 1'b1;
                            want_out_next = 1'b1;
                        end
                        OP_TEXT:
                        begin
                            cmd.op        = CELL_TEXT;
                            bit0_next     = 1'b0;
                            want_out_next = 1'b1;
                        end
                        default:
                        begin
                            cmd.op = CELL_HOLD;
                        end
                    endcase
                end
            end
            ST_RIPPLE:
            begin
                cmd.op = CELL_RIPPLE;
                // row settled: hand any result over once the output slot is free
                if (!stat.pending)
                begin
                    if (!want_out_reg)
                        state_next = ST_IDLE;
                    else if (!m_tvalid_reg || m_tready)
                    begin
                        state_next    = ST_IDLE;
                        m_tvalid_next = 1'b1;
                        res_next      = {ovf_reg, stat.matched};
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            want_out_reg <= 1'b0;
            bit0_reg     <= 1'b1;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            want_out_reg <= want_out_next;
            bit0_reg     <= bit0_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    wgm_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .bit0  (bit0_reg),
        .stat  (stat)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, res_reg};

endmodule

### rtl/wgm_checker.sv
// wgm_checker: port-level assertions for the glob matcher, bound to the top level
// depends on wildcard_glob_matcher ports only

module wgm_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic [1:0] s_tuser,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a waiting input item holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("input item changed while waiting");

    // the input is not ready in the cycle after an item is taken, while it is in the cell row
    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an item");

    // a result is loaded only from the ripple phase
    a_result_from_ripple: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without a ripple phase");

    // fill bits of the result stay zero
    a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:2] == 6'd0)
        else $error("result fill bits set");

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
